### rtl/core/ats_pkg.sv
// shared types and constants of the animated texture sampler
`default_nettype none
package ats_pkg;

    localparam int DEF_MEM_WORDS  = 65536;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_FRAMES = 64;

    localparam logic [15:0] COORD_MAX    = 16'd65470;
    localparam logic [15:0] DEFAULT_RATE = 16'd1000;
    localparam logic [16:0] FRAME_DIV    = 17'd100000;

    // product time x rate and its modulo pipeline
    localparam int PROD_W     = 48;
    localparam int MOD_BITS   = 4;
    localparam int MOD_STAGES = PROD_W / MOD_BITS;
    localparam int REM_W      = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_FRAMES = 3'd2,
        REG_RATE   = 3'd3,
        REG_LOADED = 3'd4
    } t_reg_idx;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_WRITE  = 1'b1
    } t_req;

    typedef struct packed {
        logic        req_type;
        logic [15:0] write_addr;
        logic [15:0] write_pixel;
        logic [15:0] coord_u;
        logic [15:0] coord_v;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    // per-item data that rides along the pipeline
    typedef struct packed {
        logic        req;
        logic        ok_wr;
        logic [15:0] waddr;
        logic [15:0] wpix;
        logic [8:0]  x;
        logic [8:0]  y;
    } t_side;

    function automatic logic [7:0] widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] c);
        return {c, c[5:4]};
    endfunction

endpackage
`default_nettype wire

### rtl/core/ats_stream_if.sv
// valid/ready stream channel
`default_nettype none
interface ats_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/core/animated_rgb565_texture_sampler_top.sv
// Animated RGB565 nearest-neighbour texture sampler. Takes one item (pixel write or
// sample) per clock while the output is not stalled and returns one result per item
// in order. The 12-stage modulo chain picks the animation frame (4 bits of the
// 48-bit time x rate product per stage); the pixel memory has one port, used by
// either a write or a read in the last stage, so writes and samples keep their order.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while no item is
// in flight; derived size checks are registered through r_wh, r_whn and r_sizes_ok.
// No clearing pass: pixel memory is undefined until written.
`default_nettype none
module animated_rgb565_texture_sampler_top #(
    parameter int MEM_WORDS  = ats_pkg::DEF_MEM_WORDS,
    parameter int MAX_WIDTH  = ats_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ats_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_FRAMES = ats_pkg::DEF_MAX_FRAMES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ats_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ats_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ats_stream_if.sink                           i_in,
    ats_stream_if.source                         o_out
);
    import ats_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int NS = MOD_STAGES + 5;
    localparam int ST_FRAME = MOD_STAGES + 1;
    localparam int ST_MUL   = MOD_STAGES + 2;
    localparam int ST_IDX   = MOD_STAGES + 3;
    localparam int ST_MEM   = MOD_STAGES + 4;

    // configuration and derived values
    logic [8:0]  r_w, r_h;
    logic [6:0]  r_n;
    logic [15:0] r_rate;
    logic        r_loaded;
    logic [17:0] r_wh;
    logic [24:0] r_whn;
    logic [REM_W-1:0] r_m;
    logic        r_sizes_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= '0;
            r_h        <= '0;
            r_n        <= '0;
            r_rate     <= '0;
            r_loaded   <= 1'b0;
            r_wh       <= '0;
            r_whn      <= '0;
            r_m        <= '0;
            r_sizes_ok <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WIDTH:  r_w      <= i_cfg_data[8:0];
                    REG_HEIGHT: r_h      <= i_cfg_data[8:0];
                    REG_FRAMES: r_n      <= i_cfg_data[6:0];
                    REG_RATE:   r_rate   <= i_cfg_data;
                    REG_LOADED: r_loaded <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_wh       <= 18'(r_w * r_h);
            r_whn      <= 25'(r_wh * r_n);
            r_m        <= REM_W'(r_n * FRAME_DIV);
            r_sizes_ok <= (r_w != '0) && (r_h != '0) && (r_n != '0)
                       && (32'(r_w) <= 32'(MAX_WIDTH)) && (32'(r_h) <= 32'(MAX_HEIGHT))
                       && (32'(r_n) <= 32'(MAX_FRAMES))
                       && (32'(r_whn) <= 32'(MEM_WORDS));
        end
    end

    // stage handshake: a stage moves when it is empty or its successor moves
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: clamp, texel products, time x rate
    logic [15:0]       u_c, v_c, rate_eff;
    logic [24:0]       xp, yp;
    logic [PROD_W-1:0] prod;

    always_comb begin
        u_c      = (i_in.payload.coord_u > COORD_MAX) ? COORD_MAX : i_in.payload.coord_u;
        v_c      = (i_in.payload.coord_v > COORD_MAX) ? COORD_MAX : i_in.payload.coord_v;
        rate_eff = (r_rate == '0) ? DEFAULT_RATE : r_rate;
        xp       = 25'(u_c * r_w);
        yp       = 25'(v_c * r_h);
        prod     = PROD_W'(i_in.payload.time_ms) * PROD_W'(rate_eff);
    end

    t_side             r_side [0:ST_IDX];
    logic [REM_W-1:0]  r_rem  [0:MOD_STAGES];
    logic [PROD_W-1:0] r_dvd  [0:MOD_STAGES-1];
    logic [REM_W-1:0]  n_rem  [1:MOD_STAGES];
    logic [PROD_W-1:0] n_dvd  [1:MOD_STAGES-1];
    t_side             side_clamp;

    // texel coordinates clamped to the last row and column
    always_comb begin
        side_clamp   = r_side[0];
        side_clamp.x = (r_side[0].x >= r_w) ? r_w - 9'd1 : r_side[0].x;
        side_clamp.y = (r_side[0].y >= r_h) ? r_h - 9'd1 : r_side[0].y;
    end

    // restoring modulo by frames x 100000, four dividend bits per stage
    always_comb begin
        logic [REM_W:0]    t;
        logic [PROD_W-1:0] d;
        for (int k = 1; k <= MOD_STAGES; k++) begin
            t = {1'b0, r_rem[k-1]};
            d = r_dvd[k-1];
            for (int b = 0; b < MOD_BITS; b++) begin
                t = {t[REM_W-1:0], d[PROD_W-1]};
                d = {d[PROD_W-2:0], 1'b0};
                if (t >= {1'b0, r_m}) begin
                    t = t - {1'b0, r_m};
                end
            end
            n_rem[k] = t[REM_W-1:0];
        end
        for (int k = 1; k < MOD_STAGES; k++) begin
            n_dvd[k] = r_dvd[k-1] << MOD_BITS;
        end
    end

    // frame = remainder / 100000, at most seven quotient bits; zero for fewer than two frames
    logic [6:0] n_frame;
    always_comb begin
        logic [30:0] t;
        t = 31'(r_rem[MOD_STAGES]);
        n_frame = '0;
        for (int j = 6; j >= 0; j--) begin
            if (t >= (31'(FRAME_DIV) << j)) begin
                t = t - (31'(FRAME_DIV) << j);
                n_frame[j] = 1'b1;
            end
        end
        if (r_n <= 7'd1) begin
            n_frame = '0;
        end
    end

    logic [6:0]    r_frame;
    logic [24:0]   r_fo;
    logic [17:0]   r_yw;
    logic [AW-1:0] r_idx;
    logic          r_sok;
    logic [25:0]   idx_sum;

    assign idx_sum = 26'(r_fo) + 26'(r_yw) + 26'(r_side[ST_MUL].x);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0].req   <= i_in.payload.req_type;
            r_side[0].ok_wr <= 32'(i_in.payload.write_addr) < 32'(MEM_WORDS);
            r_side[0].waddr <= i_in.payload.write_addr;
            r_side[0].wpix  <= i_in.payload.write_pixel;
            r_side[0].x     <= xp[24:16];
            r_side[0].y     <= yp[24:16];
            r_rem[0]        <= '0;
            r_dvd[0]        <= prod;
        end
        if (en[1]) begin
            r_side[1] <= side_clamp;
        end
        for (int k = 2; k <= ST_IDX; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
        for (int k = 1; k <= MOD_STAGES; k++) begin
            if (en[k]) begin
                r_rem[k] <= n_rem[k];
            end
        end
        for (int k = 1; k < MOD_STAGES; k++) begin
            if (en[k]) begin
                r_dvd[k] <= n_dvd[k];
            end
        end
        if (en[ST_FRAME]) begin
            r_frame <= n_frame;
        end
        if (en[ST_MUL]) begin
            r_fo <= 25'(r_frame * r_wh);
            r_yw <= 18'(r_side[ST_FRAME].y * r_w);
        end
        if (en[ST_IDX]) begin
            r_idx <= (32'(idx_sum) >= 32'(MEM_WORDS)) ? '0 : AW'(idx_sum);
            r_sok <= r_loaded && r_sizes_ok;
        end
    end

    // pixel memory, one port: a write or a read in the last stage
    logic [15:0] mem [0:MEM_WORDS-1];
    logic [15:0] r_word;
    logic        r_ook, r_owr;
    logic        do_wr;

    assign do_wr = r_v[ST_IDX] && (r_side[ST_IDX].req == REQ_WRITE)
                && r_side[ST_IDX].ok_wr;

    always_ff @(posedge i_clk) begin
        if (en[ST_MEM]) begin
            if (do_wr) begin
                mem[AW'(r_side[ST_IDX].waddr)] <= r_side[ST_IDX].wpix;
            end else begin
                r_word <= mem[r_idx];
            end
            r_owr <= (r_side[ST_IDX].req == REQ_WRITE);
            r_ook <= (r_side[ST_IDX].req == REQ_WRITE) ? r_side[ST_IDX].ok_wr : r_sok;
        end
    end

    logic show;
    assign show = r_ook && !r_owr;

    assign o_out.valid         = r_v[ST_MEM];
    assign o_out.payload.ok    = r_ook;
    assign o_out.payload.red   = show ? widen5(r_word[15:11]) : 8'd0;
    assign o_out.payload.green = show ? widen6(r_word[10:5])  : 8'd0;
    assign o_out.payload.blue  = show ? widen5(r_word[4:0])   : 8'd0;

endmodule
`default_nettype wire
